/* src/lsni_pkg.sv */
// ----------------------------------------------------------------------------
// lsni_pkg: shared types and constants for the line/sphere Newton solver
// Holds the sequencer state type, status codes, register indexes and
// saturation helper used by the datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lsni_pkg;

    localparam int ACC_W   = 64;   // accumulator / product width
    localparam int QUO_W   = 31;   // magnitude of the Newton step
    localparam int OP_LAST = 10;   // last slot of one evaluation pass
    localparam int HIT_LAST = 3;   // last slot of the final point pass
    localparam int SLOT_W  = 4;

    // solve status codes
    localparam logic [1:0] STATUS_CONV  = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_PORE_X = 3'd0;
    localparam logic [2:0] REG_PORE_Y = 3'd1;
    localparam logic [2:0] REG_PORE_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS = 3'd3;
    localparam logic [2:0] REG_GUESS  = 3'd4;
    localparam logic [2:0] REG_TOL    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHK,
        ST_DIV,
        ST_STEP,
        ST_HIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_res_t;

    // clamp a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/lsni_mul.sv */
// ----------------------------------------------------------------------------
// lsni_mul: shared signed multiplier
// One 32x32 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none
module lsni_mul (
    input  wire logic                               aclk,
    input  wire logic signed [31:0]                 op_a,
    input  wire logic signed [31:0]                 op_b,
    output logic signed [lsni_pkg::ACC_W-1:0]       prod
);
    logic signed [lsni_pkg::ACC_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

/* src/lsni_div.sv */
// ----------------------------------------------------------------------------
// lsni_div: serial fixed-point divider
// Computes min(floor(num * 2^F / den), 2^31-1) one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lsni_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [lsni_pkg::ACC_W-1:0]     num,
    input  wire logic [lsni_pkg::ACC_W-1:0]     den,
    output lsni_pkg::div_res_t                  res
);
    localparam int QW = lsni_pkg::QUO_W;
    localparam int AW = lsni_pkg::ACC_W;
    localparam int WW = AW + QW;
    localparam int SH = QW - FRAC_BITS;
    localparam int CW = $clog2(QW);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rem_reg, den_reg;
    logic [QW-1:0] q_reg;

    logic [WW-1:0] num_w, den_w, num_sh;
    logic          sat;
    logic [AW:0]   rem_sh;
    logic          qbit;

    // overflow test, initial split of the shifted numerator and the restoring compare
    always_comb begin
        num_w  = {{QW{1'b0}}, num};
        den_w  = {{QW{1'b0}}, den} << SH;
        num_sh = num_w << FRAC_BITS;
        sat    = (num_w >= den_w);
        rem_sh = {rem_reg, q_reg[QW-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (sat) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring step; quotient bits shift in behind the numerator bits
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= num >> SH;
            q_reg   <= sat ? {QW{1'b1}} : num_sh[QW-1:0];
        end else if (busy_reg) begin
            rem_reg <= qbit ? AW'(rem_sh - {1'b0, den_reg}) : rem_sh[AW-1:0];
            q_reg   <= {q_reg[QW-2:0], qbit};
        end
    end

    assign res.done = done_reg;
    assign res.quo  = q_reg;
endmodule
`default_nettype wire

/* src/line_sphere_newton_intersect.sv */
// ----------------------------------------------------------------------------
// line_sphere_newton_intersect: Newton solver for line/sphere intersection
// Forms dir = atom - pore, then iterates t -= f/(2g) on |dir*t+pore|^2 = r^2
// with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
//  channel  | ports               | payload
//  ---------+---------------------+-----------------------------------------
//  input    | s_tvalid/s_tready   | s_tdata: atom_x, atom_y, atom_z
//  result   | m_tvalid/m_tready   | m_tdata: line_param, hit_x/y/z; m_tuser: status
//  config   | cfg_we              | cfg_addr, cfg_wdata
//
// Sequence: each Newton pass runs the multiply slots, a check, the divider wait
// and an update; the shared multiplier and the one-bit-per-cycle divider set
// how long an item takes.
// Reset: synchronous active-low aresetn resets control and config registers only.
// A finished word waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module line_sphere_newton_intersect #(
    parameter int MAX_ITER  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // atom_x, atom_y, atom_z
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,   // line_param, hit_x, hit_y, hit_z
    output logic [1:0]         m_tuser,   // solve_status
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata
);
    localparam int AW = lsni_pkg::ACC_W;
    localparam int NW = $clog2(MAX_ITER + 1);
    localparam int SW = lsni_pkg::SLOT_W;

    // configuration
    logic [31:0] pore_reg [3];
    logic [30:0] radius_reg;
    logic [31:0] guess_reg;
    logic [15:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pore_reg[0] <= '0;
            pore_reg[1] <= '0;
            pore_reg[2] <= '0;
            radius_reg  <= 31'd65536;
            guess_reg   <= 32'd65536;
            tol_reg     <= 16'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lsni_pkg::REG_PORE_X: pore_reg[0] <= cfg_wdata;
                lsni_pkg::REG_PORE_Y: pore_reg[1] <= cfg_wdata;
                lsni_pkg::REG_PORE_Z: pore_reg[2] <= cfg_wdata;
                lsni_pkg::REG_RADIUS: radius_reg  <= cfg_wdata[30:0];
                lsni_pkg::REG_GUESS:  guess_reg   <= cfg_wdata;
                lsni_pkg::REG_TOL:    tol_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    lsni_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;

    logic [31:0]           d_reg [3];
    logic [31:0]           p_reg [3];
    logic [31:0]           t_reg, t_next;
    logic signed [AW-1:0]  f_reg, g_reg;
    logic [127:0]          m_data_reg;
    logic [1:0]            m_user_reg;

    // shared units
    logic signed [31:0]    mul_a, mul_b;
    logic signed [AW-1:0]  prod;
    logic                  div_start;
    logic [AW-1:0]         div_num, div_den;
    lsni_pkg::div_res_t    div_res;

    lsni_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    lsni_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // operand select for the slot being issued
    logic [1:0] lane;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        lane  = '0;
        unique case (slot_reg)
            4'd0, 4'd1, 4'd2: begin
                lane  = slot_reg[1:0];
                mul_a = d_reg[lane];
                mul_b = t_reg;
            end
            4'd3: begin
                mul_a = {1'b0, radius_reg};
                mul_b = {1'b0, radius_reg};
            end
            4'd4, 4'd5, 4'd6: begin
                lane  = 2'(slot_reg - 4'd4);
                mul_a = p_reg[lane];
                mul_b = p_reg[lane];
            end
            4'd7, 4'd8, 4'd9: begin
                lane  = 2'(slot_reg - 4'd7);
                mul_a = d_reg[lane];
                mul_b = p_reg[lane];
            end
            default: ;
        endcase
    end

    // divider operands: |f| over |2g|
    logic signed [AW-1:0] g2;
    logic signed [AW-1:0] prod_fl;
    always_comb begin
        g2      = g_reg <<< 1;
        div_num = f_reg[AW-1] ? AW'(-f_reg) : f_reg;
        div_den = g2[AW-1] ? AW'(-g2) : g2;
        prod_fl = prod >>> FRAC_BITS;
    end

    // Newton update
    logic signed [AW-1:0] h_val, t_diff;
    logic                 step_small;
    always_comb begin
        h_val  = (f_reg[AW-1] ^ g_reg[AW-1]) ? -AW'(div_res.quo) : AW'(div_res.quo);
        t_diff = {{32{t_reg[31]}}, t_reg} - h_val;
        step_small = ({1'b0, div_res.quo} < {16'd0, tol_reg});
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        n_next       = n_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        t_next       = t_reg;
        div_start    = 1'b0;
        s_tready     = (state_reg == lsni_pkg::ST_IDLE);
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            lsni_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lsni_pkg::ST_EVAL;
                    slot_next  = '0;
                    n_next     = '0;
                    t_next     = guess_reg;
                end
            end
            lsni_pkg::ST_EVAL: begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SW'(lsni_pkg::OP_LAST)) begin
                    state_next = lsni_pkg::ST_CHK;
                end
            end
            lsni_pkg::ST_CHK: begin
                if (g_reg == '0) begin
                    status_next = lsni_pkg::STATUS_ZERO;
                    state_next  = lsni_pkg::ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = lsni_pkg::ST_DIV;
                end
            end
            lsni_pkg::ST_DIV: begin
                if (div_res.done) begin
                    state_next = lsni_pkg::ST_STEP;
                end
            end
            lsni_pkg::ST_STEP: begin
                slot_next = '0;
                if (n_reg == '0 && step_small) begin
                    status_next = lsni_pkg::STATUS_CONV;
                    state_next  = lsni_pkg::ST_OUT;
                end else begin
                    t_next = lsni_pkg::sat32(t_diff);
                    n_next = n_reg + 1'b1;
                    if (step_small) begin
                        status_next = lsni_pkg::STATUS_CONV;
                        state_next  = lsni_pkg::ST_HIT;
                    end else if (n_reg + 1'b1 >= NW'(MAX_ITER)) begin
                        status_next = lsni_pkg::STATUS_LIMIT;
                        state_next  = lsni_pkg::ST_HIT;
                    end else begin
                        state_next = lsni_pkg::ST_EVAL;
                    end
                end
            end
            lsni_pkg::ST_HIT: begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SW'(lsni_pkg::HIT_LAST)) begin
                    state_next = lsni_pkg::ST_OUT;
                end
            end
            lsni_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = lsni_pkg::ST_IDLE;
                end
            end
            default: state_next = lsni_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsni_pkg::ST_IDLE;
            slot_reg    <= '0;
            n_reg       <= '0;
            status_reg  <= lsni_pkg::STATUS_CONV;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            n_reg       <= n_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // accumulate the product of the previous slot
    logic            consume;
    logic [SW-1:0]   cslot;
    logic [1:0]      clane;
    always_comb begin
        consume = (state_reg == lsni_pkg::ST_EVAL || state_reg == lsni_pkg::ST_HIT)
                  && slot_reg != '0;
        cslot   = slot_reg - 1'b1;
        clane   = cslot[1:0];
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
        if (state_reg == lsni_pkg::ST_IDLE && s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= lsni_pkg::sat32({{32{s_tdata[32*i+31]}}, s_tdata[32*i +: 32]}
                                          - {{32{pore_reg[i][31]}}, pore_reg[i]});
            end
        end
        if (consume) begin
            priority if (cslot < 4'd3) begin
                p_reg[clane] <= lsni_pkg::sat32(prod_fl
                                  + {{32{pore_reg[clane][31]}}, pore_reg[clane]});
            end else if (cslot == 4'd3) begin
                f_reg <= -prod_fl;
                g_reg <= '0;
            end else if (cslot < 4'd7) begin
                f_reg <= f_reg + prod_fl;
            end else begin
                g_reg <= g_reg + prod_fl;
            end
        end
        if (state_reg == lsni_pkg::ST_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {p_reg[2], p_reg[1], p_reg[0], t_reg};
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // checks
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(MAX_ITER))
        else $error("iteration count past limit");
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == lsni_pkg::ST_DIV)
        else $error("divider finished outside wait state");
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == lsni_pkg::ST_EVAL && n_reg == '0)
        else $error("accepted word did not start evaluation");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("invalid status on output");
endmodule
`default_nettype wire

/* tb/sv/tb_line_sphere_newton_intersect.sv */
// ----------------------------------------------------------------------------
// tb_line_sphere_newton_intersect: self-checking bench for the Newton solver
// Drives atom positions, predicts t, the hit point and the solve status
// from an in-bench fixed-point model and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_line_sphere_newton_intersect;

    localparam int      N_ITER     = 16;
    localparam int      FRAC       = 16;
    localparam longint  S32_HI     = 64'sd2147483647;
    localparam longint  S32_LO     = -64'sd2147483648;
    localparam int      ITEM_CYC   = N_ITER * 45 + 6;
    localparam int      HOLD_LONG  = 3000;
    localparam int      IDLE_LIMIT = 4 * (HOLD_LONG + ITEM_CYC);
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int      ONE        = 65536;

    typedef struct {
        logic [31:0] t;
        logic [31:0] hx;
        logic [31:0] hy;
        logic [31:0] hz;
        logic [1:0]  status;
    } hit_word_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;    // atom_x, atom_y, atom_z
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;         // line_param, hit_x, hit_y, hit_z
    logic [1:0]    m_tuser;         // solve_status
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_addr = '0;
    logic [31:0]   cfg_wdata = '0;

    // bench copy of the register file
    longint pore_c[3];
    longint rad_c;
    longint guess_c;
    longint tol_c;

    hit_word_t hits_pending[$];
    int        errors = 0;
    int        burst_left = 0;
    bit        gaps_on = 1'b1;
    int        hold_req = 0;
    int        idle_cycles = 0;

    line_sphere_newton_intersect i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic longint clamp32(input longint x);
        if (x > S32_HI) return S32_HI;
        if (x < S32_LO) return S32_LO;
        return x;
    endfunction

    function automatic longint point_on_line(input longint d, input longint t,
                                             input longint c);
        return clamp32(((d * t) >>> FRAC) + c);
    endfunction

    function automatic longint newton_step(input longint f, input longint g);
        longint unsigned uf, ug, q, rem;
        longint m;
        uf = (f < 0) ? -f : f;
        ug = (g < 0) ? -g : g;
        q = uf / ug;
        rem = uf % ug;
        if (q >= (64'd1 << (31 - FRAC))) begin
            m = S32_HI;
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= ug) begin
                    rem = rem - ug;
                    q = q | 64'd1;
                end
            end
            m = longint'(q);
        end
        return ((f < 0) != (g < 0)) ? -m : m;
    endfunction

    function automatic hit_word_t solve_hit(input logic [95:0] atom);
        hit_word_t r;
        longint d[3], p[3];
        longint t, f, g, h, mag;
        int n;
        logic [1:0] st;
        t = guess_c;
        n = 0;
        for (int i = 0; i < 3; i++)
            d[i] = clamp32(longint'($signed(atom[32*i +: 32])) - pore_c[i]);
        forever begin
            f = -((rad_c * rad_c) >>> FRAC);
            g = 0;
            for (int i = 0; i < 3; i++) begin
                p[i] = point_on_line(d[i], t, pore_c[i]);
                f += (p[i] * p[i]) >>> FRAC;
                g += (d[i] * p[i]) >>> FRAC;
            end
            g = g * 2;
            if (g == 0) begin
                st = lsni_pkg::STATUS_ZERO;
                break;
            end
            h = newton_step(f, g);
            mag = (h < 0) ? -h : h;
            if (n == 0 && mag < tol_c) begin
                st = lsni_pkg::STATUS_CONV;
                break;
            end
            t = clamp32(t - h);
            n++;
            if (mag < tol_c) begin
                st = lsni_pkg::STATUS_CONV;
                break;
            end
            if (n >= N_ITER) begin
                st = lsni_pkg::STATUS_LIMIT;
                break;
            end
        end
        r.t = t[31:0];
        r.hx = 32'(point_on_line(d[0], t, pore_c[0]));
        r.hy = 32'(point_on_line(d[1], t, pore_c[1]));
        r.hz = 32'(point_on_line(d[2], t, pore_c[2]));
        r.status = st;
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("%0t: %s mismatch: expected %h got %h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    always @(posedge aclk) begin
        hit_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hits_pending.size() == 0) begin
                report_mismatch("unexpected word", '0, m_tdata[31:0]);
            end else begin
                e = hits_pending.pop_front();
                if (m_tdata[31:0] !== e.t)     report_mismatch("line_param", e.t, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.hx)   report_mismatch("hit_x", e.hx, m_tdata[63:32]);
                if (m_tdata[95:64] !== e.hy)   report_mismatch("hit_y", e.hy, m_tdata[95:64]);
                if (m_tdata[127:96] !== e.hz)  report_mismatch("hit_z", e.hz, m_tdata[127:96]);
                if (m_tuser !== e.status)
                    report_mismatch("solve_status", 32'(e.status), 32'(m_tuser));
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_line_sphere_newton_intersect failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int mode, left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(64, 512);
            end
            left--;
            if (hold_req > 0) begin
                hold_req--;
                m_tready <= 1'b0;
            end else case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            lsni_pkg::REG_PORE_X: pore_c[0] = longint'($signed(val));
            lsni_pkg::REG_PORE_Y: pore_c[1] = longint'($signed(val));
            lsni_pkg::REG_PORE_Z: pore_c[2] = longint'($signed(val));
            lsni_pkg::REG_RADIUS: rad_c = longint'(val[30:0]);
            lsni_pkg::REG_GUESS:  guess_c = longint'($signed(val));
            lsni_pkg::REG_TOL:    tol_c = longint'(val[15:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_solver(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] r,
                              input logic [31:0] g0, input logic [31:0] tol);
        write_reg(lsni_pkg::REG_PORE_X, px);
        write_reg(lsni_pkg::REG_PORE_Y, py);
        write_reg(lsni_pkg::REG_PORE_Z, pz);
        write_reg(lsni_pkg::REG_RADIUS, r);
        write_reg(lsni_pkg::REG_GUESS, g0);
        write_reg(lsni_pkg::REG_TOL, tol);
    endtask

    // one atom word; valid stays high across back-to-back words
    task automatic send_atom(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        hits_pending.push_back(solve_hit({z, y, x}));
        if (burst_left > 0) burst_left--;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 30);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [31:0] near(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // well-formed atom near the pore, occasionally wide or full random
    task automatic send_random_atom();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            send_atom($urandom, $urandom, $urandom);
        else if (k == 1)
            send_atom(32'(pore_c[0]) + near(1 << 24), 32'(pore_c[1]) + near(1 << 24),
                      32'(pore_c[2]) + near(1 << 24));
        else
            send_atom(32'(pore_c[0]) + near(40 * ONE), 32'(pore_c[1]) + near(40 * ONE),
                      32'(pore_c[2]) + near(40 * ONE));
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        // reset values: atom at (1,0,0) sits on the sphere at the guess
        send_atom(ONE, 0, 0);
        send_atom(2 * ONE, 0, 0);
        send_atom(0, 0, 0);                       // atom on pore: zero gradient
        send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_atom(32'hFFFF_FFFF, 0, 32'h0000_0001);
        drain_results();
        // zero tolerance: never converges
        set_solver(ONE, -2 * ONE, 3 * ONE, 5 * ONE, ONE, 0);
        send_atom(7 * ONE, 5 * ONE, -ONE);
        send_atom(ONE, -2 * ONE, 3 * ONE);
        send_atom(32'h8000_0000, 32'h7FFF_FFFF, 0);
        drain_results();
        // extreme pore, radius and guess
        set_solver(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF);
        send_atom(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_atom(0, 0, 0);
        drain_results();
        set_solver(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                   32'h8000_0000, 1);
        send_atom(0, 0, 0);
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_results();
        // unused indexes are ignored
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h1234_5678);
        set_solver(0, 0, 0, 3 * ONE, ONE / 2, 16);
        send_atom(4 * ONE, 0, 0);
        send_atom(0, -ONE, ONE);
        send_atom(ONE / 4, ONE / 4, ONE / 4);
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++) begin
            gaps_on = (ph != 3);
            if (ph == 5)
                set_solver(near(4 * ONE), near(4 * ONE), near(4 * ONE),
                           $urandom_range(0, 32'h7FFF_FFFF), $urandom,
                           $urandom_range(0, 16'hFFFF));
            else
                set_solver(near(16 * ONE), near(16 * ONE), near(16 * ONE),
                           $urandom_range(ONE / 4, 24 * ONE),
                           $urandom_range(0, 2 * ONE), $urandom_range(0, 256));
            for (int i = 0; i < 90; i++) send_random_atom();
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_solver(0, 0, 0, 8 * ONE, ONE, 4);
        hold_req = HOLD_LONG;
        gaps_on = 1'b0;
        for (int i = 0; i < 12; i++) send_random_atom();
        gaps_on = 1'b1;
        drain_results();
    endtask

    initial begin
        pore_c[0] = 0;
        pore_c[1] = 0;
        pore_c[2] = 0;
        rad_c = ONE;
        guess_c = ONE;
        tol_c = 1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_output_backpressure();
        test_random_phases();
        drain_results();
        repeat (ITEM_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_line_sphere_newton_intersect passed");
        end else begin
            $display("tb_line_sphere_newton_intersect failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
src/lsni_pkg.sv
src/lsni_mul.sv
src/lsni_div.sv
src/line_sphere_newton_intersect.sv
tb/sv/tb_line_sphere_newton_intersect.sv
